/* rtl/km_pkg.sv */
// Shared constants and codes for the k-means clustering engine.
// Used by kmeans_lloyd_clustering and its port checker; depends on nothing.
package km_pkg;

  // Default sizing of the stores.
  localparam int MAX_POINTS_DEF   = 1024;
  localparam int MAX_DIMS_DEF     = 8;
  localparam int MAX_CLUSTERS_DEF = 8;

  // Fixed field widths.
  localparam int COORD_W    = 32;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int M_TDATA_W  = 40;

  // Iteration limit clamp and register reset values.
  localparam logic [9:0]  ITER_LOW      = 10'd2;
  localparam logic [9:0]  ITER_HIGH     = 10'd999;
  localparam logic [3:0]  RST_CLUSTERS  = 4'd2;
  localparam logic [3:0]  RST_DIMS      = 4'd1;
  localparam logic [9:0]  RST_MAX_ITER  = 10'd200;
  localparam logic [30:0] RST_EPSILON   = 31'd66;

  // Request opcodes carried on s_tuser.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_POINT = 2'd0,
    OP_LOAD_CENT  = 2'd1,
    OP_RUN        = 2'd2
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_CLUSTERS = 2'd0,
    CFG_NUM_DIMS     = 2'd1,
    CFG_MAX_ITER     = 2'd2,
    CFG_MOVE_EPS     = 2'd3
  } cfg_idx_t;

endpackage

/* rtl/km_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Used for the point, centroid and assignment stores; no dependencies.
module km_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/km_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Used by the clustering engine for the point count and the centroid means.
module km_div #(
  parameter int DW = 48,
  parameter int VW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [VW:0]   rem;
  logic [VW-1:0] dvs;
  logic [DW-1:0] quo;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_sub;
  logic          take;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh  = {rem[VW-1:0], quo[DW-1]};
    take    = rem_sh >= {1'b0, dvs};
    rem_sub = rem_sh - {1'b0, dvs};
  end

  // Iteration control; done pulses with the final quotient.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
        cnt  <= CW'(DW);
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[DW-2:0], take};
        rem <= take ? rem_sub : rem_sh;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

/* rtl/kmeans_lloyd_clustering.sv */
// Lloyd k-means clustering engine, top level: stores, sequencer, shared squarer.
// Depends on km_pkg, km_ram and km_div.
//
//  Channel | Direction | Handshake          | Content
//  s_*     | in        | s_tvalid/s_tready  | tuser opcode, tdata coordinate
//  m_*     | out       | m_tvalid/m_tready  | tdata cluster/dim/value, tuser status, tlast
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// Load requests are taken back to back while idle. A run first divides to count the
// points, then in each round assigns every point to its nearest centroid and updates
// the clusters, dividing for the mean of each cluster that has members, all bound by
// the one squarer and the one serial divider. Each result is then held until taken.
// Reset is synchronous; the stores need no clearing. While a run is active s_tready
// is low; a result that is not taken holds the sequencer.
module kmeans_lloyd_clustering #(
  parameter int MAX_POINTS   = km_pkg::MAX_POINTS_DEF,
  parameter int MAX_DIMS     = km_pkg::MAX_DIMS_DEF,
  parameter int MAX_CLUSTERS = km_pkg::MAX_CLUSTERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Requests: tdata = coord_value[31:0]; tuser = opcode[1:0].
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [km_pkg::COORD_W-1:0]      s_tdata,
  input  logic [km_pkg::OP_W-1:0]         s_tuser,
  // Results: tdata = cluster_index[2:0], dim_index[5:3], centroid_value[37:6],
  // zeros[39:38]; tuser = status[0].
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [km_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic [0:0]                      m_tuser,
  output logic                            m_tlast,
  // Configuration writes.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [km_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [km_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int POINT_CAP = MAX_POINTS * MAX_DIMS;
  localparam int CENT_CAP  = MAX_CLUSTERS * MAX_DIMS;
  localparam int LP_W  = $clog2(POINT_CAP + 1);
  localparam int CP_W  = $clog2(CENT_CAP + 1);
  localparam int PA_W  = POINT_CAP > 1 ? $clog2(POINT_CAP) : 1;
  localparam int CA_W  = CENT_CAP > 1 ? $clog2(CENT_CAP) : 1;
  localparam int AA_W  = MAX_POINTS > 1 ? $clog2(MAX_POINTS) : 1;
  localparam int PT_W  = $clog2(MAX_POINTS + 1);
  localparam int JW    = $clog2(MAX_DIMS + 1);
  localparam int KW    = $clog2(MAX_CLUSTERS + 1);
  localparam int ASG_W = $clog2(MAX_CLUSTERS);
  localparam int SI_W  = MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1;
  localparam int SUM_W = 33 + $clog2(MAX_POINTS);
  localparam int DVD_W = SUM_W > LP_W ? SUM_W : LP_W;
  localparam int DVS_W = PT_W > JW ? PT_W : JW;

  typedef enum logic [4:0] {
    S_IDLE, S_DIVN, S_ITER,
    S_A_PT, S_A_CL, S_A_RD, S_A_DIF, S_A_MUL, S_A_ACC, S_A_CMP,
    S_U_CL, S_U_ASG, S_U_CHK, S_U_PRD, S_U_PAC, S_U_NXT,
    S_M_RD, S_M_DIV, S_M_MUL, S_M_ACC, S_M_CHK, S_U_KNX,
    S_E_RD, S_E_LD, S_E_WT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [3:0]  num_clusters;
  logic [3:0]  num_dims;
  logic [9:0]  max_iterations;
  logic [30:0] move_epsilon;

  // Sequencer registers.
  logic [LP_W-1:0]  load_pos;
  logic [CP_W-1:0]  cent_pos;
  logic [PT_W-1:0]  n;
  logic [PT_W-1:0]  i;
  logic [JW-1:0]    j;
  logic [KW-1:0]    k;
  logic [KW-1:0]    bi;
  logic [LP_W-1:0]  pbase;
  logic [CP_W-1:0]  cbase;
  logic [9:0]       iter;
  logic             settled;
  logic [63:0]      acc;
  logic [63:0]      best;
  logic [63:0]      eps2;
  logic [31:0]      mul_op;
  logic [63:0]      prod;
  logic             mean_neg;
  logic [PT_W-1:0]  member;
  logic signed [SUM_W-1:0] sums [MAX_DIMS];

  // Derived values.
  logic [JW-1:0]    d;
  logic [9:0]       lim;
  logic [KW-1:0]    kc;
  logic             j_last;
  logic             k_last;
  logic             i_last;
  logic             accept;
  logic [km_pkg::OP_W-1:0] op;
  logic [64:0]      acc_sum;
  logic [63:0]      acc_sat;
  logic             better;
  logic [KW-1:0]    new_bi;
  logic [DVD_W-1:0] n_clamp;
  logic             k_ok;

  // Store ports.
  logic             pt_we;
  logic [31:0]      pt_rd;
  logic             ct_we;
  logic [CA_W-1:0]  ct_waddr;
  logic [31:0]      ct_wdata;
  logic [31:0]      ct_rd;
  logic             as_we;
  logic [ASG_W-1:0] as_rd;

  // Divider ports.
  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;

  logic signed [SUM_W-1:0] sum_j;
  logic [SUM_W-1:0] sum_mag;
  logic [31:0]      qlow;
  logic [31:0]      newv;
  logic [32:0]      diff_a;
  logic [32:0]      diff_m;
  logic [31:0]      mag_a;
  logic [31:0]      mag_m;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign op        = s_tuser;

  // Clamp the dimension and iteration registers.
  always_comb begin
    if (num_dims == '0) begin
      d = JW'(1);
    end else if (32'(num_dims) > MAX_DIMS) begin
      d = JW'(MAX_DIMS);
    end else begin
      d = JW'(num_dims);
    end
    if (max_iterations < km_pkg::ITER_LOW) begin
      lim = km_pkg::ITER_LOW;
    end else if (max_iterations > km_pkg::ITER_HIGH) begin
      lim = km_pkg::ITER_HIGH;
    end else begin
      lim = max_iterations;
    end
  end

  assign kc     = KW'(num_clusters);
  assign j_last = (j == JW'(d - 1'b1));
  assign k_last = (k == KW'(kc - 1'b1));
  assign i_last = (i == PT_W'(n - 1'b1));

  // Saturating distance accumulation and nearest-centroid compare.
  always_comb begin
    acc_sum = {1'b0, acc} + {1'b0, prod};
    acc_sat = acc_sum[64] ? '1 : acc_sum[63:0];
    better  = (k == '0) || (acc < best);
    new_bi  = better ? k : bi;
  end

  // Point count check after the count division.
  always_comb begin
    n_clamp = (div_quo > DVD_W'(MAX_POINTS)) ? DVD_W'(MAX_POINTS) : div_quo;
    k_ok    = (num_clusters >= 4'd2) && (32'(num_clusters) <= MAX_CLUSTERS) &&
              (DVD_W'(num_clusters) < n_clamp);
  end

  // Coordinate differences for the squarer.
  always_comb begin
    sum_j   = sums[SI_W'(j)];
    sum_mag = sum_j[SUM_W-1] ? SUM_W'(-sum_j) : SUM_W'(sum_j);
    qlow    = div_quo[31:0];
    newv    = mean_neg ? 32'(-qlow) : qlow;
    diff_a  = {pt_rd[31], pt_rd} - {ct_rd[31], ct_rd};
    diff_m  = {ct_rd[31], ct_rd} - {newv[31], newv};
    mag_a   = diff_a[32] ? 32'(-diff_a) : diff_a[31:0];
    mag_m   = diff_m[32] ? 32'(-diff_m) : diff_m[31:0];
  end

  // Divider request: point count at run start, centroid mean during update.
  always_comb begin
    div_start = 1'b0;
    div_dvd   = DVD_W'(load_pos);
    div_dvs   = DVS_W'(d);
    if (state == S_M_RD) begin
      div_start = 1'b1;
      div_dvd   = DVD_W'(sum_mag) + DVD_W'(member >> 1);
      div_dvs   = DVS_W'(member);
    end else if (accept && op == km_pkg::OP_RUN) begin
      div_start = 1'b1;
    end
  end

  // Store write control.
  always_comb begin
    pt_we    = accept && (op == km_pkg::OP_LOAD_POINT) && (32'(load_pos) < POINT_CAP);
    ct_we    = 1'b0;
    ct_waddr = CA_W'(cbase + CP_W'(j));
    ct_wdata = newv;
    if (state == S_M_DIV && div_done) begin
      ct_we = 1'b1;
    end else if (accept && op == km_pkg::OP_LOAD_CENT && 32'(cent_pos) < CENT_CAP) begin
      ct_we    = 1'b1;
      ct_waddr = CA_W'(cent_pos);
      ct_wdata = s_tdata;
    end
    as_we = (state == S_A_CMP) && k_last;
  end

  km_ram #(.WIDTH(32), .DEPTH(POINT_CAP)) u_points (
    .clk   (clk),
    .we    (pt_we),
    .waddr (PA_W'(load_pos)),
    .wdata (s_tdata),
    .raddr (PA_W'(pbase + LP_W'(j))),
    .rdata (pt_rd)
  );

  km_ram #(.WIDTH(32), .DEPTH(CENT_CAP)) u_centroids (
    .clk   (clk),
    .we    (ct_we),
    .waddr (ct_waddr),
    .wdata (ct_wdata),
    .raddr (CA_W'(cbase + CP_W'(j))),
    .rdata (ct_rd)
  );

  km_ram #(.WIDTH(ASG_W), .DEPTH(MAX_POINTS)) u_assign (
    .clk   (clk),
    .we    (as_we),
    .waddr (AA_W'(i)),
    .wdata (ASG_W'(new_bi)),
    .raddr (AA_W'(i)),
    .rdata (as_rd)
  );

  km_div #(.DW(DVD_W), .VW(DVS_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Shared squarer, one product per cycle.
  always_ff @(posedge clk) begin
    prod <= mul_op * mul_op;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters   <= km_pkg::RST_CLUSTERS;
      num_dims       <= km_pkg::RST_DIMS;
      max_iterations <= km_pkg::RST_MAX_ITER;
      move_epsilon   <= km_pkg::RST_EPSILON;
    end else if (cfg_valid && cfg_ready) begin
      unique case (km_pkg::cfg_idx_t'(cfg_index))
        km_pkg::CFG_NUM_CLUSTERS: num_clusters   <= cfg_data[3:0];
        km_pkg::CFG_NUM_DIMS:     num_dims       <= cfg_data[3:0];
        km_pkg::CFG_MAX_ITER:     max_iterations <= cfg_data[9:0];
        km_pkg::CFG_MOVE_EPS:     move_epsilon   <= cfg_data[30:0];
      endcase
    end
  end

  // Main sequencer with registered result outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      load_pos <= '0;
      cent_pos <= '0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (op == km_pkg::OP_LOAD_POINT) begin
              if (32'(load_pos) < POINT_CAP) load_pos <= load_pos + 1'b1;
            end else if (op == km_pkg::OP_LOAD_CENT) begin
              if (32'(cent_pos) < CENT_CAP) cent_pos <= cent_pos + 1'b1;
            end else if (op == km_pkg::OP_RUN) begin
              mul_op   <= {1'b0, move_epsilon};
              load_pos <= '0;
              cent_pos <= '0;
              state    <= S_DIVN;
            end
          end
        end
        S_DIVN: begin
          if (div_done) begin
            n       <= PT_W'(n_clamp);
            eps2    <= prod;
            iter    <= '0;
            settled <= 1'b0;
            if (k_ok) begin
              state <= S_ITER;
            end else begin
              m_tvalid <= 1'b1;
              m_tdata  <= '0;
              m_tuser  <= 1'b1;
              m_tlast  <= 1'b1;
              state    <= S_E_WT;
            end
          end
        end
        S_ITER: begin
          k     <= '0;
          j     <= '0;
          cbase <= '0;
          i     <= '0;
          pbase <= '0;
          if (!settled && iter < lim) begin
            settled <= 1'b1;
            state   <= S_A_PT;
          end else begin
            state <= S_E_RD;
          end
        end
        // Assignment: nearest centroid for point i.
        S_A_PT: begin
          k     <= '0;
          cbase <= '0;
          state <= S_A_CL;
        end
        S_A_CL: begin
          j     <= '0;
          acc   <= '0;
          state <= S_A_RD;
        end
        S_A_RD: state <= S_A_DIF;
        S_A_DIF: begin
          mul_op <= mag_a;
          state  <= S_A_MUL;
        end
        S_A_MUL: state <= S_A_ACC;
        S_A_ACC: begin
          acc <= acc_sat;
          if (j_last) begin
            state <= S_A_CMP;
          end else begin
            j     <= j + 1'b1;
            state <= S_A_RD;
          end
        end
        S_A_CMP: begin
          if (better) begin
            best <= acc;
            bi   <= k;
          end
          if (!k_last) begin
            k     <= k + 1'b1;
            cbase <= cbase + CP_W'(d);
            state <= S_A_CL;
          end else if (i_last) begin
            k     <= '0;
            cbase <= '0;
            state <= S_U_CL;
          end else begin
            i     <= i + 1'b1;
            pbase <= pbase + LP_W'(d);
            state <= S_A_PT;
          end
        end
        // Update: sum the members of cluster k.
        S_U_CL: begin
          for (int x = 0; x < MAX_DIMS; x++) sums[x] <= '0;
          member <= '0;
          i      <= '0;
          pbase  <= '0;
          state  <= S_U_ASG;
        end
        S_U_ASG: state <= S_U_CHK;
        S_U_CHK: begin
          j <= '0;
          if (KW'(as_rd) == k) begin
            state <= S_U_PRD;
          end else begin
            state <= S_U_NXT;
          end
        end
        S_U_PRD: state <= S_U_PAC;
        S_U_PAC: begin
          sums[SI_W'(j)] <= sum_j + SUM_W'($signed(pt_rd));
          if (j_last) begin
            member <= member + 1'b1;
            state  <= S_U_NXT;
          end else begin
            j     <= j + 1'b1;
            state <= S_U_PRD;
          end
        end
        S_U_NXT: begin
          if (!i_last) begin
            i     <= i + 1'b1;
            pbase <= pbase + LP_W'(d);
            state <= S_U_ASG;
          end else if (member == '0) begin
            state <= S_U_KNX;
          end else begin
            j     <= '0;
            acc   <= '0;
            state <= S_M_RD;
          end
        end
        // Mean per coordinate and squared movement.
        S_M_RD: begin
          mean_neg <= sum_j[SUM_W-1];
          state    <= S_M_DIV;
        end
        S_M_DIV: begin
          if (div_done) begin
            mul_op <= mag_m;
            state  <= S_M_MUL;
          end
        end
        S_M_MUL: state <= S_M_ACC;
        S_M_ACC: begin
          acc <= acc_sat;
          if (j_last) begin
            state <= S_M_CHK;
          end else begin
            j     <= j + 1'b1;
            state <= S_M_RD;
          end
        end
        S_M_CHK: begin
          if (acc > eps2) settled <= 1'b0;
          state <= S_U_KNX;
        end
        S_U_KNX: begin
          if (k_last) begin
            iter  <= iter + 1'b1;
            state <= S_ITER;
          end else begin
            k     <= k + 1'b1;
            cbase <= cbase + CP_W'(d);
            state <= S_U_CL;
          end
        end
        // Result emission, one coordinate per result.
        S_E_RD: state <= S_E_LD;
        S_E_LD: begin
          m_tvalid <= 1'b1;
          m_tdata  <= {2'b00, ct_rd, 3'(j), 3'(k)};
          m_tuser  <= 1'b0;
          m_tlast  <= k_last && j_last;
          state    <= S_E_WT;
        end
        S_E_WT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              state <= S_IDLE;
            end else if (j_last) begin
              j     <= '0;
              k     <= k + 1'b1;
              cbase <= cbase + CP_W'(d);
              state <= S_E_RD;
            end else begin
              j     <= j + 1'b1;
              state <= S_E_RD;
            end
          end
        end
      endcase
    end
  end

endmodule

/* rtl/km_chk.sv */
// Port-level checker for kmeans_lloyd_clustering, attached by bind.
// Depends on km_pkg for the request opcodes.
module km_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [km_pkg::OP_W-1:0]       s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [km_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic [0:0]                    m_tuser,
  input logic                          m_tlast
);

  // No request is taken while a result is pending.
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("request ready while a result is pending");

  // A run request makes the block busy.
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == km_pkg::OP_RUN) |=> !s_tready)
    else $error("still ready after a run request");

  // An error result is the only result of its run and carries zero data.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tlast && m_tdata == '0))
    else $error("error result not final or not zero");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

bind kmeans_lloyd_clustering km_chk u_km_chk (.*);
